// ===== hw/rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg - shared types and constants for the line span hasher
// Span limit, byte codes, hash constants, the record carried from the
// span tracker to the hash reduction pipeline, and the accumulator mix step.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

   localparam int MaxSpan    = 64;
   localparam int CountWidth = $clog2(MaxSpan + 1);

   localparam logic [7:0] ByteLf = 8'h0A;
   localparam logic [7:0] ByteCr = 8'h0D;

   localparam int MixShift   = 7;
   localparam int CrossShift = 25;

   localparam logic [31:0] HashMult  = 32'h61;
   localparam logic [16:0] HashPrime = 17'd107927;

   // quotient estimate: q = (sum[31:TopShift] * HashRecip) >> RecipShift
   localparam int TopShift   = 15;
   localparam int RecipShift = 24;
   localparam logic [22:0] HashRecip =
      23'((64'd1 << (TopShift + RecipShift)) / 64'd107927);

   typedef struct packed {
      logic [31:0] high;
      logic [31:0] low;
   } mix_type;

   typedef struct packed {
      logic [CountWidth-1:0] length;
      logic                  crlf;
      logic                  last_of_run;
      logic                  buffer_done;
   } rsp_meta_type;

   typedef struct packed {
      mix_type      mix;
      rsp_meta_type meta;
   } span_rec_type;

   function automatic mix_type mix_step(mix_type m, logic [7:0] c);
      mix_type r;
      r.high = ((m.high << MixShift) ^ (m.low >> CrossShift)) + {24'd0, c};
      r.low  = (m.low << MixShift) ^ (m.high >> CrossShift);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsh_span.sv =====
// ----------------------------------------------------------------------------
// lsh_span - span tracker
// Absorbs one byte per beat into the accumulators, handles the held CR,
// closes spans and queues up to two span records for the hash pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_span (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 text_mode,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   output logic                      rec_valid,
   input  wire logic                 rec_ready,
   output lsh_pkg::span_rec_type     rec
);

   localparam int CW = lsh_pkg::CountWidth;

   lsh_pkg::mix_type      mix_ff, mix_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  held_ff, held_in;
   logic                  crlf_ff, crlf_in;

   lsh_pkg::span_rec_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]            fill_ff, fill_in;

   logic                  accept, pop;
   logic                  is_lf, is_cr, do_cr, emit_a, absorb_b, emit_b, valid_b;
   logic                  crlf_now;
   lsh_pkg::mix_type      mix_cr, base_mix, mix_b;
   logic [CW-1:0]         count_cr, base_count, count_b;
   lsh_pkg::span_rec_type rec_a, rec_b;

   always_comb begin
      is_lf    = (in_byte == lsh_pkg::ByteLf);
      is_cr    = (in_byte == lsh_pkg::ByteCr);
      crlf_now = crlf_ff | (held_ff & is_lf);

      // held CR goes in first unless text mode drops it before LF
      do_cr    = held_ff & (~is_lf | ~text_mode);
      mix_cr   = lsh_pkg::mix_step(mix_ff, lsh_pkg::ByteCr);
      count_cr = count_ff + CW'(1);
      emit_a   = do_cr & (count_cr >= CW'(lsh_pkg::MaxSpan));

      base_mix   = mix_ff;
      base_count = count_ff;
      if (emit_a) begin
         base_mix   = '0;
         base_count = '0;
      end else if (do_cr) begin
         base_mix   = mix_cr;
         base_count = count_cr;
      end

      absorb_b = ~(is_cr & ~in_last);
      mix_b    = base_mix;
      count_b  = base_count;
      if (absorb_b) begin
         mix_b   = lsh_pkg::mix_step(base_mix, in_byte);
         count_b = base_count + CW'(1);
      end
      emit_b  = absorb_b & ((count_b >= CW'(lsh_pkg::MaxSpan)) | is_lf);
      valid_b = emit_b | (in_last & (count_b != '0));

      rec_a.mix              = mix_cr;
      rec_a.meta.length      = count_cr;
      rec_a.meta.crlf        = crlf_now;
      rec_a.meta.last_of_run = ~valid_b;
      rec_a.meta.buffer_done = in_last & ~valid_b;

      rec_b.mix              = mix_b;
      rec_b.meta.length      = count_b;
      rec_b.meta.crlf        = crlf_now;
      rec_b.meta.last_of_run = 1'b1;
      rec_b.meta.buffer_done = in_last;
   end

   assign rec_valid = (fill_ff != 2'd0);
   assign rec       = slot0_ff;
   assign pop       = rec_valid & rec_ready;
   // new beat only when everything queued is gone by the next edge
   assign in_ready  = (fill_ff == 2'd0) | ((fill_ff == 2'd1) & pop);
   assign accept    = in_valid & in_ready;

   always_comb begin
      mix_in   = mix_ff;
      count_in = count_ff;
      held_in  = held_ff;
      crlf_in  = crlf_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;

      if (accept) begin
         if (in_last) begin
            mix_in   = '0;
            count_in = '0;
            held_in  = 1'b0;
            crlf_in  = 1'b0;
         end else begin
            mix_in   = emit_b ? '0 : mix_b;
            count_in = emit_b ? '0 : count_b;
            held_in  = is_cr;
            crlf_in  = crlf_now;
         end
         slot0_in = emit_a ? rec_a : rec_b;
         slot1_in = rec_b;
         fill_in  = {1'b0, emit_a} + {1'b0, valid_b};
      end else if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff   <= '0;
         count_ff <= '0;
         held_ff  <= 1'b0;
         crlf_ff  <= 1'b0;
         fill_ff  <= 2'd0;
      end else begin
         mix_ff   <= mix_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         crlf_ff  <= crlf_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsh_hash.sv =====
// ----------------------------------------------------------------------------
// lsh_hash - hash reduction pipeline
// Folds the two accumulators into one word, then reduces it modulo the
// hash prime with a reciprocal multiply and a small correction.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_hash (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rec_valid,
   output logic                       rec_ready,
   input  wire lsh_pkg::span_rec_type rec,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [16:0]                out_hash,
   output lsh_pkg::rsp_meta_type      out_meta
);

   localparam int TS = lsh_pkg::TopShift;
   localparam int RS = lsh_pkg::RecipShift;
   localparam int QW = 32 - TS + 23 - RS;

   logic                  v1_ff, v2_ff, v3_ff;
   logic                  rdy1, rdy2, rdy3;
   logic [31:0]           sum1_ff, sum2_ff;
   lsh_pkg::rsp_meta_type meta1_ff, meta2_ff, meta3_ff;
   logic [QW-1:0]         quot2_ff;
   logic [16:0]           hash3_ff;

   logic [31:0]           sum;
   logic [39:0]           prod;
   logic [32:0]           qp;
   logic [31:0]           diff;
   logic [18:0]           rem;
   logic [18:0]           prime1, prime2;
   logic [18:0]           hash;

   assign rdy3      = ~v3_ff | out_ready;
   assign rdy2      = ~v2_ff | rdy3;
   assign rdy1      = ~v1_ff | rdy2;
   assign rec_ready = rdy1;

   assign sum  = rec.mix.high + rec.mix.low * lsh_pkg::HashMult;
   assign prod = 40'(sum1_ff[31:TS]) * 40'(lsh_pkg::HashRecip);

   // estimate is at most two below the true quotient
   assign qp     = 33'(quot2_ff) * 33'(lsh_pkg::HashPrime);
   assign diff   = sum2_ff - qp[31:0];
   assign rem    = diff[18:0];
   assign prime1 = 19'(lsh_pkg::HashPrime);
   assign prime2 = {prime1[17:0], 1'b0};

   always_comb begin
      if (rem >= prime2) begin
         hash = rem - prime2;
      end else if (rem >= prime1) begin
         hash = rem - prime1;
      end else begin
         hash = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= rec_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         sum1_ff  <= sum;
         meta1_ff <= rec.meta;
      end
      if (rdy2) begin
         sum2_ff  <= sum1_ff;
         quot2_ff <= prod[RS +: QW];
         meta2_ff <= meta1_ff;
      end
      if (rdy3) begin
         hash3_ff <= hash[16:0];
         meta3_ff <= meta2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_hash  = hash3_ff;
   assign out_meta  = meta3_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/line_span_hasher.sv =====
// ----------------------------------------------------------------------------
// line_span_hasher - cuts a byte stream into spans and hashes each span
// Top level: mode register, span tracker and hash reduction pipeline.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless the tracker's queue holds a record not being
// taken. A span closes at a line feed, after 64 counted bytes, or at the
// buffer's last byte (req_tlast); each closed span gives one result beat with
// its hash modulo 107927 and its length. A byte that closes two spans (a held
// CR filling a span, then the byte itself) gives two result beats and holds
// req_tready low while the tracker's two-entry queue drains. Each result is
// registered in the tracker's queue, then in the hash pipeline's fold,
// quotient and correction stages. A CR is held until the next byte; in text
// mode (csr_wr_data written as 1) a CR right before LF is dropped. rsp_tuser
// marks the last result of a byte, rsp_tlast the last span of the buffer.
`default_nettype none

module line_span_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_buffer
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [16:0] span_hash, [23:17] span_length,
                                         // [24] crlf_seen, [31:25] zero
   output logic             rsp_tuser,   // last_of_run
   output logic             rsp_tlast    // buffer_done
);

   logic                  text_mode_ff;
   logic                  rec_valid, rec_ready;
   lsh_pkg::span_rec_type rec;
   logic [16:0]           out_hash;
   lsh_pkg::rsp_meta_type out_meta;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         text_mode_ff <= csr_wr_data;
      end
   end

   lsh_span u_span (
      .clock     (clock),
      .reset     (reset),
      .text_mode (text_mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec)
   );

   lsh_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hash  (out_hash),
      .out_meta  (out_meta)
   );

   assign rsp_tdata = {7'd0, out_meta.crlf, out_meta.length, out_hash};
   assign rsp_tuser = out_meta.last_of_run;
   assign rsp_tlast = out_meta.buffer_done;

endmodule

`default_nettype wire

// ===== tb/line_span_checker.sv =====
// ----------------------------------------------------------------------------
// line_span_checker - span hash scoreboard for line_span_hasher
// Tracks every accepted input beat and mode write, works out the spans each
// byte closes with their hash, length and flags, and compares them in order
// against the result beats the block hands out.
// ----------------------------------------------------------------------------
module line_span_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          spans_pending
);

   typedef struct packed {
      logic [16:0] hash;
      logic [6:0]  length;
      logic        crlf;
      logic        run_end;
      logic        buf_end;
   } span_result_type;

   // shadow of the block's state
   logic        text_mode;
   logic [31:0] acc_hi;
   logic [31:0] acc_lo;
   logic [6:0]  span_len;
   logic        cr_held;
   logic        crlf_hit;

   span_result_type spans_due[$];
   span_result_type byte_spans[0:1];
   int              byte_span_n;
   int              errs;

   assign mismatch_count = errs;

   task automatic close_span();
      span_result_type r;
      logic [31:0]     folded;
      folded    = acc_hi + acc_lo * lsh_pkg::HashMult;
      r.hash    = 17'(folded % {15'd0, lsh_pkg::HashPrime});
      r.length  = span_len;
      r.crlf    = crlf_hit;
      r.run_end = 1'b0;
      r.buf_end = 1'b0;
      byte_spans[byte_span_n] = r;
      byte_span_n++;
      acc_hi   = '0;
      acc_lo   = '0;
      span_len = '0;
   endtask

   task automatic mix_in(input logic [7:0] c);
      logic [31:0] old_hi;
      old_hi   = acc_hi;
      acc_hi   = ((acc_hi << lsh_pkg::MixShift) ^ (acc_lo >> lsh_pkg::CrossShift))
                 + {24'd0, c};
      acc_lo   = (acc_lo << lsh_pkg::MixShift) ^ (old_hi >> lsh_pkg::CrossShift);
      span_len = span_len + 7'd1;
      if (32'(span_len) >= lsh_pkg::MaxSpan || c == lsh_pkg::ByteLf)
         close_span();
   endtask

   task automatic track_byte(input logic [7:0] c, input logic eob);
      byte_span_n = 0;
      // a CR held from the previous beat is resolved by this byte
      if (cr_held) begin
         cr_held = 1'b0;
         if (c == lsh_pkg::ByteLf) begin
            crlf_hit = 1'b1;
            if (!text_mode)
               mix_in(lsh_pkg::ByteCr);
         end else begin
            mix_in(lsh_pkg::ByteCr);
         end
      end
      if (c == lsh_pkg::ByteCr && !eob)
         cr_held = 1'b1;
      else
         mix_in(c);
      if (eob) begin
         if (span_len != 7'd0)
            close_span();
         if (byte_span_n > 0)
            byte_spans[byte_span_n-1].buf_end = 1'b1;
         acc_hi   = '0;
         acc_lo   = '0;
         span_len = '0;
         cr_held  = 1'b0;
         crlf_hit = 1'b0;
      end
      if (byte_span_n > 0)
         byte_spans[byte_span_n-1].run_end = 1'b1;
      for (int i = 0; i < byte_span_n; i++)
         spans_due.push_back(byte_spans[i]);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errs++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_span();
      span_result_type want;
      if (spans_due.size() == 0) begin
         errs++;
         $display("%0t: result beat with none expected: expected nothing, actual tdata=%h",
                  $time, rsp_tdata);
      end else begin
         want = spans_due.pop_front();
         compare_field("span_hash", 32'(want.hash), 32'(rsp_tdata[16:0]));
         compare_field("span_length", 32'(want.length), 32'(rsp_tdata[23:17]));
         compare_field("crlf_seen", 32'(want.crlf), 32'(rsp_tdata[24]));
         compare_field("tdata pad", 32'd0, 32'(rsp_tdata[31:25]));
         compare_field("last_of_run", 32'(want.run_end), 32'(rsp_tuser));
         compare_field("buffer_done", 32'(want.buf_end), 32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         text_mode = 1'b0;
         acc_hi    = '0;
         acc_lo    = '0;
         span_len  = '0;
         cr_held   = 1'b0;
         crlf_hit  = 1'b0;
         errs      = 0;
         spans_due.delete();
      end else begin
         if (csr_wr_en)
            text_mode = csr_wr_data;
         if (req_tvalid && req_tready)
            track_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_span();
      end
      spans_pending = spans_due.size();
   end

endmodule

// ===== tb/tb_line_span_hasher.sv =====
// ----------------------------------------------------------------------------
// tb_line_span_hasher - testbench for the line span hasher
// Drives byte buffers (directed corner cases, then random text-like and long
// buffers) with random gaps and result-side stalls, switches the text mode
// between buffers and while a CR is held, and leaves checking to the
// line_span_checker scoreboard.
// ----------------------------------------------------------------------------
module tb_line_span_hasher;

   localparam int IdleLimit   = 4000;
   localparam int RandomItems = 450;
   localparam int DrainCycles = 8;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int   mismatches;
   int   spans_pending;
   int   bytes_sent;
   int   idle_cycles = 0;
   logic send_gaps;

   line_span_hasher u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   line_span_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatches),
      .spans_pending  (spans_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_byte(input int lf_pct, input int cr_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < lf_pct)
         return lsh_pkg::ByteLf;
      if (r < lf_pct + cr_pct)
         return lsh_pkg::ByteCr;
      if (r < 70)
         return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // result side: random stalls, with a stall-free stretch every third window
   initial begin
      int stall_left;
      int cycle;
      rsp_tready = 1'b0;
      stall_left = 0;
      cycle      = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (stall_left > 0)
            stall_left--;
         else if ((cycle / 256) % 3 != 2 && $urandom_range(0, 5) == 0)
            stall_left = idle_len();
         rsp_tready = (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_byte(input logic [7:0] b, input logic eob);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat (idle_len()) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = eob;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // wait for every expected span, then let the pipeline empty
   task automatic settle();
      req_tvalid = 1'b0;
      while (spans_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_mode(input logic text);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = text;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic send_buffer();
      int         kind;
      int         len;
      logic [7:0] b;
      kind      = $urandom_range(0, 9);
      send_gaps = ($urandom_range(0, 3) != 0);
      if (kind == 9) begin
         // 63 plain bytes, then a CR that fills the span and a byte after it
         for (int i = 0; i < 63; i++)
            send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         send_byte(lsh_pkg::ByteCr, 1'b0);
         send_byte(pick_byte(30, 10), 1'($urandom_range(0, 1)));
      end else begin
         len = (kind < 6) ? $urandom_range(1, 40) : $urandom_range(60, 150);
         for (int i = 0; i < len; i++) begin
            b = (kind < 6) ? pick_byte(10, 8) : pick_byte(1, 3);
            send_byte(b, i == len - 1);
            if (b == lsh_pkg::ByteCr && i != len - 1 && $urandom_range(0, 15) == 0)
               set_mode(1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      int target;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      send_gaps   = 1'b0;
      bytes_sent  = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // binary mode: byte extremes, LF close, CRLF hashed whole
      set_mode(1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(lsh_pkg::ByteLf, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(lsh_pkg::ByteLf, 1'b0);
      send_byte(8'h7F, 1'b1);
      // CR as last byte is never held; CR before another byte is kept
      send_byte(lsh_pkg::ByteCr, 1'b1);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(8'h80, 1'b1);
      // text mode: CRLF drops the CR, CR CR keeps the first
      set_mode(1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(lsh_pkg::ByteLf, 1'b0);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      send_byte(lsh_pkg::ByteLf, 1'b1);
      // mode flips while a CR is held: the mode at the LF decides
      send_byte(lsh_pkg::ByteCr, 1'b0);
      set_mode(1'b0);
      send_byte(lsh_pkg::ByteLf, 1'b1);
      send_byte(lsh_pkg::ByteCr, 1'b0);
      set_mode(1'b1);
      send_byte(lsh_pkg::ByteLf, 1'b0);
      send_byte(8'hFE, 1'b1);

      target = RandomItems;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 2) == 0)
            set_mode(1'($urandom_range(0, 1)));
         send_buffer();
      end
      req_tvalid = 1'b0;

      while (spans_pending != 0) @(negedge clock);
      repeat (2 * DrainCycles) @(negedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lsh_pkg.sv
hw/rtl/lsh_span.sv
hw/rtl/lsh_hash.sv
hw/rtl/line_span_hasher.sv
tb/line_span_checker.sv
tb/tb_line_span_hasher.sv
